// ===== design/sprite_scanline_evaluator_assert.svh =====
// Assertion macros for the sprite scanline evaluator.
`ifndef SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH
`define SPRITE_SCANLINE_EVALUATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define SSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sprite evaluator check failed");
`define SSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sprite evaluator check failed");
`else
`define SSE_ASSERT_IMP(lbl, ante, cons)
`define SSE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== design/sse_pkg.sv =====
package sse_pkg;

  localparam int ENTRY_COUNT_DEF = 64;
  localparam int SLOT_COUNT_DEF  = 8;

  localparam logic [4:0] HEIGHT_SHORT = 5'd8;
  localparam logic [4:0] HEIGHT_TALL  = 5'd16;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } cmd_t;

  localparam int BYTE_LANES = 4;

endpackage

// ===== design/sprite_scanline_evaluator.sv =====
// Sprite scanline evaluator.
//
// Input channel (in_valid/in_ready) carries one transaction per command. A
// write command stores in_store_byte at in_store_address of the attribute
// store; writes beyond the store are dropped. It returns nothing. An
// evaluate command scans the entries in index order against in_line_number,
// one entry compare per cycle out of a single-port store with a registered
// read; the scan stops early once a match past the last slot is seen.
// Results then leave on the output channel (out_valid/out_ready), one per
// selected sprite, or a single not-found result, last on the final one.
// Overflow and sprite-zero marks are known only after the scan, so no
// result leaves before it ends. A receiver stall holds the current result;
// no new command is accepted until the last result of an evaluation has
// been taken. Reset clears the configuration, the state machine and one
// valid bit per store row; a row that was never written reads as all zeros,
// so the store behaves as cleared at once, with no clearing pass.
`include "sprite_scanline_evaluator_assert.svh"

module sprite_scanline_evaluator #(
  parameter int ENTRY_COUNT = sse_pkg::ENTRY_COUNT_DEF,
  parameter int SLOT_COUNT  = sse_pkg::SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_sprite_tall_we,
  input  logic       cfg_sprite_tall,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_command,
  input  logic [7:0] in_store_address,
  input  logic [7:0] in_store_byte,
  input  logic [8:0] in_line_number,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_found,
  output logic [2:0] out_slot,
  output logic [7:0] out_sprite_y,
  output logic [7:0] out_sprite_tile,
  output logic [7:0] out_sprite_attributes,
  output logic [7:0] out_sprite_x,
  output logic [5:0] out_entry_index,
  output logic       out_sprite_zero_seen,
  output logic       out_overflow,
  output logic       out_last
);
  import sse_pkg::*;

  localparam int ROW_W      = $clog2(ENTRY_COUNT);
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int StoreBytes = ENTRY_COUNT * BYTE_LANES;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ENTRY_COUNT - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_PREP,
    ST_EMIT
  } state_t;

  // Attribute store: one 32-bit row per entry, y in the low byte.
  logic [31:0]      store_mem [ENTRY_COUNT];
  logic             row_valid_r [ENTRY_COUNT];
  logic             mem_rd_en;
  logic [ROW_W-1:0] mem_rd_addr;
  logic [31:0]      rd_data_r;
  logic             rd_valid_r;
  logic             mem_we;
  logic [31:0]      mem_wr_data;
  logic [31:0]      row_data;

  state_t           state_r, state_nxt;
  logic             tall_r;
  logic [8:0]       line_r, line_nxt;
  logic [ROW_W-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             more_r, more_nxt;
  logic             zero_r, zero_nxt;
  logic [ROW_W-1:0] wb_row_r, wb_row_nxt;
  logic [1:0]       wb_lane_r, wb_lane_nxt;
  logic [7:0]       wb_byte_r, wb_byte_nxt;
  logic             wb_en_r, wb_en_nxt;

  logic [31:0]           slot_data_r [SLOT_COUNT];
  logic [ROW_W-1:0]      slot_idx_r  [SLOT_COUNT];
  logic                  slot_we;
  logic [SLOT_IDX_W-1:0] slot_wr_sel;

  logic [SLOT_IDX_W-1:0] out_k_r, out_k_nxt;
  logic [SLOT_IDX_W-1:0] rd_k;
  logic                  load_out;
  logic                  out_valid_r, out_valid_nxt;
  logic                  out_found_r;
  logic [2:0]            out_slot_r;
  logic [31:0]           out_data_r;
  logic [5:0]            out_index_r;
  logic                  out_zero_r, out_over_r, out_last_r;

  logic             in_fire;
  logic [7:0]       addr_row;
  logic [9:0]       diff;
  logic [4:0]       height;
  logic             covers;
  logic [7:0]       idx_wide;
  logic [7:0]       k_wide;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign addr_row = {2'b00, in_store_address[7:2]};
  assign row_data = rd_valid_r ? rd_data_r : 32'd0;

  assign height = tall_r ? HEIGHT_TALL : HEIGHT_SHORT;
  assign diff   = {1'b0, line_r} - {2'b00, row_data[7:0]};
  assign covers = !diff[9] && (diff[8:0] < {4'b0000, height});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tall_r <= 1'b0;
    end else if (cfg_sprite_tall_we) begin
      tall_r <= cfg_sprite_tall;
    end
  end

  // Byte merge for the write path.
  always_comb begin
    mem_wr_data = row_data;
    for (int b = 0; b < BYTE_LANES; b++) begin
      if (wb_lane_r == 2'(b)) begin
        mem_wr_data[b*8 +: 8] = wb_byte_r;
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    line_nxt      = line_r;
    cmp_idx_nxt   = cmp_idx_r;
    cnt_nxt       = cnt_r;
    more_nxt      = more_r;
    zero_nxt      = zero_r;
    wb_row_nxt    = wb_row_r;
    wb_lane_nxt   = wb_lane_r;
    wb_byte_nxt   = wb_byte_r;
    wb_en_nxt     = wb_en_r;
    out_k_nxt     = out_k_r;
    out_valid_nxt = out_valid_r;
    mem_rd_en     = 1'b0;
    mem_rd_addr   = '0;
    mem_we        = 1'b0;
    slot_we       = 1'b0;
    slot_wr_sel   = cnt_r[SLOT_IDX_W-1:0];
    load_out      = 1'b0;
    rd_k          = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_command == CMD_EVAL) begin
            line_nxt    = in_line_number;
            cmp_idx_nxt = '0;
            cnt_nxt     = '0;
            more_nxt    = 1'b0;
            zero_nxt    = 1'b0;
            mem_rd_en   = 1'b1;
            mem_rd_addr = '0;
            state_nxt   = ST_SCAN;
          end else begin
            wb_row_nxt  = addr_row[ROW_W-1:0];
            wb_lane_nxt = in_store_address[1:0];
            wb_byte_nxt = in_store_byte;
            wb_en_nxt   = int'(in_store_address) < StoreBytes;
            mem_rd_en   = int'(in_store_address) < StoreBytes;
            mem_rd_addr = addr_row[ROW_W-1:0];
            state_nxt   = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        mem_we    = wb_en_r;
        state_nxt = ST_IDLE;
      end
      ST_SCAN: begin
        // Row cmp_idx_r is on the read port; fetch the next one behind it.
        mem_rd_en   = (cmp_idx_r != LAST_ROW);
        mem_rd_addr = cmp_idx_r + 1'b1;
        cmp_idx_nxt = cmp_idx_r + 1'b1;
        if (cmp_idx_r == LAST_ROW) begin
          state_nxt = ST_PREP;
        end
        if (covers) begin
          if (cnt_r < CNT_W'(SLOT_COUNT)) begin
            slot_we = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
            if (cmp_idx_r == '0) begin
              zero_nxt = 1'b1;
            end
          end else begin
            more_nxt  = 1'b1;
            mem_rd_en = 1'b0;
            state_nxt = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        rd_k          = '0;
        out_k_nxt     = '0;
        load_out      = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_ready) begin
          if (out_last_r) begin
            out_valid_nxt = 1'b0;
            state_nxt     = ST_IDLE;
          end else begin
            rd_k      = out_k_r + 1'b1;
            out_k_nxt = out_k_r + 1'b1;
            load_out  = 1'b1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign idx_wide = 8'(slot_idx_r[rd_k]);
  assign k_wide   = 8'(rd_k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
    line_r    <= line_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    more_r    <= more_nxt;
    zero_r    <= zero_nxt;
    wb_row_r  <= wb_row_nxt;
    wb_lane_r <= wb_lane_nxt;
    wb_byte_r <= wb_byte_nxt;
    wb_en_r   <= wb_en_nxt;
    out_k_r   <= out_k_nxt;
    if (slot_we) begin
      slot_data_r[slot_wr_sel] <= row_data;
      slot_idx_r[slot_wr_sel]  <= cmp_idx_r;
    end
    if (load_out) begin
      if (cnt_r == '0) begin
        out_found_r <= 1'b0;
        out_slot_r  <= 3'd0;
        out_data_r  <= 32'd0;
        out_index_r <= 6'd0;
        out_zero_r  <= 1'b0;
        out_over_r  <= 1'b0;
        out_last_r  <= 1'b1;
      end else begin
        out_found_r <= 1'b1;
        out_slot_r  <= k_wide[2:0];
        out_data_r  <= slot_data_r[rd_k];
        out_index_r <= idx_wide[5:0];
        out_zero_r  <= zero_r;
        out_over_r  <= more_r;
        out_last_r  <= (CNT_W'(rd_k) + 1'b1) == cnt_r;
      end
    end
  end

  // Store array and its read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[wb_row_r] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      rd_data_r <= store_mem[mem_rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENTRY_COUNT; i++) begin
        row_valid_r[i] <= 1'b0;
      end
      rd_valid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        row_valid_r[wb_row_r] <= 1'b1;
      end
      if (mem_rd_en) begin
        rd_valid_r <= row_valid_r[mem_rd_addr];
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = out_found_r;
  assign out_slot              = out_slot_r;
  assign out_sprite_y          = out_data_r[7:0];
  assign out_sprite_tile       = out_data_r[15:8];
  assign out_sprite_attributes = out_data_r[23:16];
  assign out_sprite_x          = out_data_r[31:24];
  assign out_entry_index       = out_index_r;
  assign out_sprite_zero_seen  = out_zero_r;
  assign out_overflow          = out_over_r;
  assign out_last              = out_last_r;

  `SSE_ASSERT_IMP(a_no_accept_during_emit, out_valid_r, !in_ready)
  `SSE_ASSERT_IMP(a_count_bounded, 1'b1, cnt_r <= CNT_W'(SLOT_COUNT))
  `SSE_ASSERT_IMP(a_not_found_clean, out_valid_r && !out_found_r,
                  out_last_r && !out_over_r && !out_zero_r)
  `SSE_ASSERT_IMP(a_overflow_full, out_valid_r && out_over_r,
                  out_found_r && (cnt_r == CNT_W'(SLOT_COUNT)))
  `SSE_ASSERT_NXT(a_write_returns_idle, state_r == ST_WRITE, state_r == ST_IDLE)

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import sse_pkg::*;

  localparam int unsigned STORE_BYTES      = ENTRY_COUNT_DEF * BYTE_LANES;
  localparam int unsigned LANE_Y           = 0;
  localparam int unsigned LANE_TILE        = 1;
  localparam int unsigned LANE_ATTR        = 2;
  localparam int unsigned LANE_X           = 3;
  localparam int unsigned SETTLE_CYCLES    = 8;
  localparam int unsigned LONG_HOLD_CYCLES = 400;
  localparam int unsigned FRAME_COUNT      = 28;
  localparam int unsigned DRAIN_LIMIT      = 20000;
  localparam int unsigned TAIL_CYCLES      = 100;
  localparam int unsigned TIMEOUT_CYCLES   = 400000;

  typedef struct {
    logic       found;
    logic [2:0] slot;
    logic [7:0] sprite_y;
    logic [7:0] sprite_tile;
    logic [7:0] sprite_attributes;
    logic [7:0] sprite_x;
    logic [5:0] entry_index;
    logic       zero_seen;
    logic       overflow;
    logic       last;
  } sprite_report_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_sprite_tall_we = 1'b0;
  logic       cfg_sprite_tall = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       in_command = 1'b0;
  logic [7:0] in_store_address = '0;
  logic [7:0] in_store_byte = '0;
  logic [8:0] in_line_number = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       out_found;
  logic [2:0] out_slot;
  logic [7:0] out_sprite_y;
  logic [7:0] out_sprite_tile;
  logic [7:0] out_sprite_attributes;
  logic [7:0] out_sprite_x;
  logic [5:0] out_entry_index;
  logic       out_sprite_zero_seen;
  logic       out_overflow;
  logic       out_last;

  // Our own copy of the attribute store and the height register.
  logic [7:0]     store_copy [STORE_BYTES] = '{default: '0};
  logic           tall_copy = 1'b0;
  sprite_report_t expected_reports [$];

  int unsigned mismatch_count = 0;
  int unsigned in_gap_max = 5;
  int unsigned out_gap_max = 5;
  int unsigned ready_wait = 0;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;

  sprite_scanline_evaluator dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_sprite_tall_we    (cfg_sprite_tall_we),
    .cfg_sprite_tall       (cfg_sprite_tall),
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_command            (in_command),
    .in_store_address      (in_store_address),
    .in_store_byte         (in_store_byte),
    .in_line_number        (in_line_number),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_found             (out_found),
    .out_slot              (out_slot),
    .out_sprite_y          (out_sprite_y),
    .out_sprite_tile       (out_sprite_tile),
    .out_sprite_attributes (out_sprite_attributes),
    .out_sprite_x          (out_sprite_x),
    .out_entry_index       (out_entry_index),
    .out_sprite_zero_seen  (out_sprite_zero_seen),
    .out_overflow          (out_overflow),
    .out_last              (out_last)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #(TIMEOUT_CYCLES * 10);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("MISMATCH at %0t ns: %s", $time, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    end
  endtask

  // Scan the entries in index order and queue the reports the block owes for this line.
  task automatic predict_scan(input logic [8:0] line);
    int unsigned    hits [$];
    int unsigned    ln;
    int unsigned    height;
    int unsigned    top;
    int unsigned    base;
    logic           spill;
    logic           zero_hit;
    sprite_report_t r;
    ln = 32'(line);
    spill = 1'b0;
    zero_hit = 1'b0;
    height = 32'(tall_copy ? HEIGHT_TALL : HEIGHT_SHORT);
    for (int e = 0; e < ENTRY_COUNT_DEF; e++) begin
      top = 32'(store_copy[e * BYTE_LANES + LANE_Y]);
      if (ln >= top && ln - top < height) begin
        if (hits.size() == SLOT_COUNT_DEF) begin
          spill = 1'b1;
          break;
        end
        hits.push_back(e);
        if (e == 0) begin
          zero_hit = 1'b1;
        end
      end
    end
    if (hits.size() == 0) begin
      r = '{default: '0};
      r.last = 1'b1;
      expected_reports.push_back(r);
    end else begin
      foreach (hits[k]) begin
        base = hits[k] * BYTE_LANES;
        r.found = 1'b1;
        r.slot = 3'(k);
        r.sprite_y = store_copy[base + LANE_Y];
        r.sprite_tile = store_copy[base + LANE_TILE];
        r.sprite_attributes = store_copy[base + LANE_ATTR];
        r.sprite_x = store_copy[base + LANE_X];
        r.entry_index = 6'(hits[k]);
        r.zero_seen = zero_hit;
        r.overflow = spill;
        r.last = (k == hits.size() - 1);
        expected_reports.push_back(r);
      end
    end
  endtask

  // Returns at the edge where the transaction is taken; valid is left high so
  // that a following command can go out back to back.
  task automatic issue_command(input cmd_t cmd, input logic [7:0] addr, input logic [7:0] value,
                               input logic [8:0] line);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_store_address <= addr;
    in_store_byte <= value;
    in_line_number <= line;
    do @(posedge clk); while (!in_ready);
    if (cmd == CMD_WRITE) begin
      if (addr < STORE_BYTES) begin
        store_copy[addr] = value;
      end
    end else begin
      predict_scan(line);
    end
  endtask

  task automatic write_byte(input logic [7:0] addr, input logic [7:0] value);
    issue_command(CMD_WRITE, addr, value, 9'($urandom));
  endtask

  task automatic evaluate_line(input logic [8:0] line);
    issue_command(CMD_EVAL, 8'($urandom), 8'($urandom), line);
  endtask

  // A write leaves no result behind, so keep waiting past the last report.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_sprite_height(input logic tall);
    wait_for_results();
    cfg_sprite_tall <= tall;
    cfg_sprite_tall_we <= 1'b1;
    @(posedge clk);
    cfg_sprite_tall_we <= 1'b0;
    tall_copy = tall;
  endtask

  // Every entry starts at row zero, so the top rows overflow and lower rows are empty.
  task automatic test_cleared_store();
    evaluate_line(9'd0);
    evaluate_line(9'd7);
    evaluate_line(9'd8);
    evaluate_line(9'd511);
  endtask

  task automatic test_tall_sprites();
    set_sprite_height(1'b1);
    evaluate_line(9'd15);
    evaluate_line(9'd16);
    write_byte(8'd0, 8'hFF);
    write_byte(8'd252, 8'hFF);
    write_byte(8'd253, 8'hFF);
    write_byte(8'd254, 8'hFF);
    write_byte(8'd255, 8'hFF);
    evaluate_line(9'd255);
    evaluate_line(9'd270);
    evaluate_line(9'd271);
    set_sprite_height(1'b0);
    evaluate_line(9'd262);
    evaluate_line(9'd263);
    evaluate_line(9'd256);
  endtask

  // Exactly eight entries on one line, then a ninth one joins them.
  task automatic test_slot_boundary();
    int unsigned             top;
    int unsigned             e;
    int unsigned             pick [$];
    bit [ENTRY_COUNT_DEF-1:0] member;
    logic [7:0]              y;
    top = $urandom_range(40, 200);
    member = '0;
    if ($urandom_range(0, 1)) begin
      member[0] = 1'b1;
      pick.push_back(0);
    end
    while (pick.size() < SLOT_COUNT_DEF + 1) begin
      e = $urandom_range(0, ENTRY_COUNT_DEF - 1);
      if (!member[e]) begin
        member[e] = 1'b1;
        pick.push_back(e);
      end
    end
    pick.shuffle();
    for (int i = 0; i < ENTRY_COUNT_DEF; i++) begin
      if (member[i] && i != pick[SLOT_COUNT_DEF]) begin
        y = 8'(top);
      end else if ($urandom_range(0, 1)) begin
        y = 8'(top + 16 + $urandom_range(0, 255 - top - 16));
      end else begin
        y = 8'($urandom_range(0, top - 16));
      end
      write_byte(8'(i * BYTE_LANES + LANE_Y), y);
    end
    evaluate_line(9'(top));
    evaluate_line(9'(top + (tall_copy ? 15 : 7)));
    write_byte(8'(pick[SLOT_COUNT_DEF] * BYTE_LANES + LANE_Y), 8'(top));
    evaluate_line(9'(top));
    evaluate_line(9'(top + $urandom_range(0, 7)));
    set_sprite_height(1'b1);
    evaluate_line(9'(top + 15));
    evaluate_line(9'(top + 16));
  endtask

  task automatic test_backpressure();
    in_gap_max = 0;
    hold_toggle <= ~hold_toggle;
    repeat (6) begin
      evaluate_line(9'(store_copy[$urandom_range(0, ENTRY_COUNT_DEF - 1) * BYTE_LANES + LANE_Y]
                       + $urandom_range(0, 7)));
    end
    // The sender stays quiet until every report has drained.
    wait_for_results();
    in_gap_max = 5;
    repeat (3) begin
      write_byte(8'($urandom), 8'($urandom));
      evaluate_line(9'($urandom_range(0, 511)));
    end
  endtask

  // Each frame grows a cluster of sprites around one row and scans lines near it.
  task automatic test_random_frames();
    int unsigned hot;
    int unsigned e;
    int unsigned lane;
    logic [7:0]  value;
    logic        quiet;
    for (int frame = 0; frame < FRAME_COUNT; frame++) begin
      if (frame % 6 == 5) begin
        set_sprite_height(1'($urandom_range(0, 1)));
      end
      quiet = (frame % 5 == 3);
      in_gap_max = quiet ? 0 : 5;
      out_gap_max <= quiet ? 0 : 5;
      hot = 32'(store_copy[$urandom_range(0, ENTRY_COUNT_DEF - 1) * BYTE_LANES + LANE_Y]);
      repeat (6) begin
        e = $urandom_range(0, ENTRY_COUNT_DEF - 1);
        lane = $urandom_range(LANE_Y, LANE_X);
        if (lane == LANE_Y && $urandom_range(0, 3) != 0) begin
          value = 8'(hot - $urandom_range(0, 7));
        end else begin
          value = 8'($urandom);
        end
        write_byte(8'(e * BYTE_LANES + lane), value);
      end
      repeat (3) begin
        if ($urandom_range(0, 4) == 0) begin
          evaluate_line(9'($urandom_range(0, 511)));
        end else begin
          evaluate_line(9'(hot + $urandom_range(0, 16)));
        end
      end
    end
    out_gap_max <= 5;
  endtask

  // Result side: random gaps after each transaction, now and then before one,
  // and one long hold when the test flips hold_toggle.
  always @(posedge clk) begin : result_receiver
    int unsigned gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_wait <= 0;
      hold_seen <= 1'b0;
    end else if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      ready_wait <= LONG_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (ready_wait != 0) begin
      ready_wait <= ready_wait - 1;
      out_ready <= (ready_wait == 1);
    end else if (out_valid && out_ready) begin
      gap = $urandom_range(0, out_gap_max);
      ready_wait <= gap;
      out_ready <= (gap == 0);
    end else if (out_gap_max != 0 && $urandom_range(0, 7) == 0) begin
      ready_wait <= $urandom_range(1, out_gap_max);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : report_checker
    sprite_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_reports.size() == 0) begin
        report_mismatch("result transaction with no report pending");
      end else begin
        want = expected_reports.pop_front();
        check_field("found", 8'(out_found), 8'(want.found));
        check_field("slot", 8'(out_slot), 8'(want.slot));
        check_field("sprite_y", out_sprite_y, want.sprite_y);
        check_field("sprite_tile", out_sprite_tile, want.sprite_tile);
        check_field("sprite_attributes", out_sprite_attributes, want.sprite_attributes);
        check_field("sprite_x", out_sprite_x, want.sprite_x);
        check_field("entry_index", 8'(out_entry_index), 8'(want.entry_index));
        check_field("sprite_zero_seen", 8'(out_sprite_zero_seen), 8'(want.zero_seen));
        check_field("overflow", 8'(out_overflow), 8'(want.overflow));
        check_field("last", 8'(out_last), 8'(want.last));
      end
    end
  end

  initial begin : regression
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cleared_store();
    test_tall_sprites();
    test_slot_boundary();
    test_backpressure();
    test_random_frames();
    in_valid <= 1'b0;
    for (int n = 0; n < DRAIN_LIMIT && expected_reports.size() != 0; n++) @(posedge clk);
    if (expected_reports.size() != 0) begin
      report_mismatch($sformatf("%0d reports never arrived", expected_reports.size()));
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/sse_pkg.sv
design/sprite_scanline_evaluator.sv
test/testbench.sv
